/* rtl/satl_pkg.sv */
// Shared types, constants and helpers for the set-associative tag lookup.
package satl_pkg;

    localparam int MAX_SETS = 64;
    localparam int MAX_WAYS = 8;

    // Largest k with 2**k <= MAX_SETS, and the row count that follows from it.
    localparam int SET_BITS  = $clog2(MAX_SETS + 1) - 1;
    localparam int SET_IDX_W = (SET_BITS > 0) ? SET_BITS : 1;
    localparam int ROWS      = 1 << SET_BITS;
    localparam int WAY_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int NPAIR     = (MAX_WAYS + 1) / 2;

    localparam int ADDR_W  = 32;
    localparam int TAG_W   = 32;
    localparam int CLOCK_W = 31;
    localparam logic [CLOCK_W-1:0] CLOCK_MAX = {CLOCK_W{1'b1}};

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 4;
    localparam logic [CFG_IDX_W-1:0] REG_CACHE_ENABLED    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REPLACE_POLICY   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOG2_BLOCK_BYTES = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LOG2_SETS_USED   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WAYS_USED        = 3'd4;

    localparam logic POLICY_LRU  = 1'b0;
    localparam logic POLICY_FIFO = 1'b1;

    typedef struct packed {
        logic               valid;
        logic [TAG_W-1:0]   tag;
        logic [CLOCK_W-1:0] last_use;
        logic [CLOCK_W-1:0] fill_order;
    } line_t;

    typedef line_t [MAX_WAYS-1:0] row_t;

    // Replacement candidate: way number and its age key
    typedef struct packed {
        logic               en;
        logic [WAY_W-1:0]   way;
        logic [CLOCK_W-1:0] key;
    } cand_t;

    function automatic logic [CLOCK_W-1:0] clock_bump(input logic [CLOCK_W-1:0] v);
        return (v == CLOCK_MAX) ? v : v + 1'b1;
    endfunction

    // Keep a unless b is enabled and strictly older: ties stay with the lower way.
    function automatic cand_t cand_min(input cand_t a, input cand_t b);
        cand_t r;
        r    = (b.en && (b.key < a.key)) ? b : a;
        r.en = a.en | b.en;
        return r;
    endfunction

endpackage

/* rtl/satl_if.sv */
// Channel interfaces: lookup request, hit/miss response, configuration write.
interface satl_req_if import satl_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] access_addr;
    modport source (output valid, output access_addr, input ready);
    modport sink   (input valid, input access_addr, output ready);
endinterface

interface satl_rsp_if import satl_pkg::*; ();
    logic valid;
    logic ready;
    logic is_hit;
    modport source (output valid, output is_hit, input ready);
    modport sink   (input valid, input is_hit, output ready);
endinterface

interface satl_cfg_if import satl_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/set_assoc_cache_tag_lookup_core.sv */
// Top level of the set-associative cache tag lookup with LRU/FIFO replacement.
//
//   channel  modport  payload              item
//   -------  -------  -------------------  ---------------------------------
//   req      sink     access_addr [31:0]   one byte address per lookup
//   rsp      source   is_hit               one hit/miss answer per lookup
//   cfg      sink     index [2:0] data[3:0] one register write, always ready
//
// A cache lookup runs as memory read, tag compare with the first half of the age
// search, then victim pick with write-back. A new lookup is taken only once the
// last has written back: each does a read-modify-write of one set row in the tag
// memory. Bypass mode answers in the next cycle. Reset clears a valid flag per
// set row at once, so no clearing pass runs. A stalled rsp holds the write-back cycle.
module set_assoc_cache_tag_lookup_core import satl_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    satl_cfg_if.sink   cfg,
    satl_req_if.sink   req,
    satl_rsp_if.source rsp
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CMP  = 2'd1;
    localparam logic [1:0] ST_UPD  = 2'd2;

    // Configuration registers
    logic       cache_enabled_reg;
    logic       replace_policy_reg;
    logic [3:0] log2_block_bytes_reg;
    logic [2:0] log2_sets_used_reg;
    logic [3:0] ways_used_reg;

    logic [1:0] state_reg, state_next;

    // Tag memory: one row holds all ways of a set
    row_t                 mem [ROWS];
    row_t                 rd_row_reg;
    logic [ROWS-1:0]      row_ok_vec_reg;
    logic                 row_ok_reg;
    logic [SET_IDX_W-1:0] set_reg;
    logic [TAG_W-1:0]     tag_reg;

    logic [CLOCK_W-1:0] access_clock_reg;
    logic [CLOCK_W-1:0] fill_clock_reg;

    logic              bypass_valid_reg;
    logic [ADDR_W-1:0] bypass_addr_reg;

    logic rsp_valid_reg;
    logic rsp_hit_reg;

    // Compare stage results
    logic             hit_any_reg;
    logic [WAY_W-1:0] hit_way_reg;
    logic             inv_any_reg;
    logic [WAY_W-1:0] inv_way_reg;
    cand_t            pair_reg [NPAIR];

    logic out_free;
    logic req_accept;
    logic cache_accept;
    logic bypass_accept;
    logic bypass_hit;
    logic mem_we;

    logic [2:0]           lss_eff;
    logic [4:0]           shift_sum;
    logic [SET_IDX_W-1:0] set_mask;
    logic [SET_IDX_W-1:0] set_in;
    logic [TAG_W-1:0]     tag_in;

    row_t                 row_clean;
    logic [4:0]           ways_eff;
    logic [MAX_WAYS-1:0]  way_en;
    logic [MAX_WAYS-1:0]  hit_vec;
    logic [MAX_WAYS-1:0]  inv_vec;
    logic                 hit_any;
    logic [WAY_W-1:0]     hit_way;
    logic                 inv_any;
    logic [WAY_W-1:0]     inv_way;
    cand_t                way_cand [MAX_WAYS];
    cand_t                pair_cand [NPAIR];

    cand_t                best;
    logic [WAY_W-1:0]     sel_way;
    logic [CLOCK_W-1:0]   acc_new;
    logic [CLOCK_W-1:0]   fill_new;
    row_t                 wr_row;

    // ---------------------------------------------------------------
    // Handshakes
    // ---------------------------------------------------------------
    assign out_free      = !rsp_valid_reg || rsp.ready;
    assign req.ready     = (state_reg == ST_IDLE) && (cache_enabled_reg || out_free);
    assign req_accept    = req.valid && req.ready;
    assign cache_accept  = req_accept && cache_enabled_reg;
    assign bypass_accept = req_accept && !cache_enabled_reg;
    assign cfg.ready     = 1'b1;

    assign rsp.valid  = rsp_valid_reg;
    assign rsp.is_hit = rsp_hit_reg;

    // Write back and hand over the answer together; hold while rsp is stalled
    assign mem_we = (state_reg == ST_UPD) && out_free;

    // ---------------------------------------------------------------
    // Address split under the current geometry
    // ---------------------------------------------------------------
    always_comb
    begin
        lss_eff   = (int'(log2_sets_used_reg) > SET_BITS) ? 3'(SET_BITS) : log2_sets_used_reg;
        shift_sum = {1'b0, log2_block_bytes_reg} + {2'b00, lss_eff};
        set_mask  = SET_IDX_W'((ADDR_W'(1) << lss_eff) - ADDR_W'(1));
        set_in    = SET_IDX_W'(req.access_addr >> log2_block_bytes_reg) & set_mask;
        tag_in    = TAG_W'(req.access_addr >> shift_sum);
    end

    assign bypass_hit = bypass_valid_reg && (bypass_addr_reg == req.access_addr);

    // ---------------------------------------------------------------
    // Compare stage: row data arrived from memory
    // ---------------------------------------------------------------
    always_comb
    begin
        row_clean = row_ok_reg ? rd_row_reg : '0;
        if (ways_used_reg == 4'd0)
            ways_eff = 5'd1;
        else if ({1'b0, ways_used_reg} > 5'(MAX_WAYS))
            ways_eff = 5'(MAX_WAYS);
        else
            ways_eff = {1'b0, ways_used_reg};

        hit_any = 1'b0;
        hit_way = '0;
        inv_any = 1'b0;
        inv_way = '0;
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            way_en[w]       = 5'(w) < ways_eff;
            hit_vec[w]      = way_en[w] && row_clean[w].valid && (row_clean[w].tag == tag_reg);
            inv_vec[w]      = way_en[w] && !row_clean[w].valid;
            way_cand[w].en  = way_en[w];
            way_cand[w].way = WAY_W'(w);
            way_cand[w].key = (replace_policy_reg == POLICY_FIFO) ?
                              row_clean[w].fill_order : row_clean[w].last_use;
        end
        // lowest matching / lowest free way
        for (int w = MAX_WAYS - 1; w >= 0; w--)
        begin
            if (hit_vec[w])
            begin
                hit_any = 1'b1;
                hit_way = WAY_W'(w);
            end
            if (inv_vec[w])
            begin
                inv_any = 1'b1;
                inv_way = WAY_W'(w);
            end
        end
        // first level of the age search: neighboring ways
        for (int p = 0; p < NPAIR; p++)
        begin
            if (2 * p + 1 < MAX_WAYS)
                pair_cand[p] = cand_min(way_cand[2 * p], way_cand[2 * p + 1]);
            else
                pair_cand[p] = way_cand[2 * p];
        end
    end

    // ---------------------------------------------------------------
    // Update stage: pick the way and build the new row
    // ---------------------------------------------------------------
    always_comb
    begin
        best = pair_reg[0];
        for (int p = 1; p < NPAIR; p++)
            best = cand_min(best, pair_reg[p]);

        if (hit_any_reg)
            sel_way = hit_way_reg;
        else if (inv_any_reg)
            sel_way = inv_way_reg;
        else
            sel_way = best.way;

        acc_new  = clock_bump(access_clock_reg);
        fill_new = clock_bump(fill_clock_reg);

        wr_row = row_clean;
        if (hit_any_reg)
        begin
            wr_row[sel_way].last_use = acc_new;
        end
        else
        begin
            wr_row[sel_way].valid      = 1'b1;
            wr_row[sel_way].tag        = tag_reg;
            wr_row[sel_way].last_use   = acc_new;
            wr_row[sel_way].fill_order = fill_new;
        end
    end

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (cache_accept) state_next = ST_CMP;
            ST_CMP:  state_next = ST_UPD;
            ST_UPD:  if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // Control registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cache_enabled_reg    <= 1'b1;
            replace_policy_reg   <= POLICY_LRU;
            log2_block_bytes_reg <= 4'd5;
            log2_sets_used_reg   <= 3'd6;
            ways_used_reg        <= 4'd8;
            state_reg            <= ST_IDLE;
            row_ok_vec_reg       <= '0;
            access_clock_reg     <= '0;
            fill_clock_reg       <= '0;
            bypass_valid_reg     <= 1'b0;
            rsp_valid_reg        <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg.valid)
            begin
                unique case (cfg.index)
                    REG_CACHE_ENABLED:    cache_enabled_reg    <= cfg.data[0];
                    REG_REPLACE_POLICY:   replace_policy_reg   <= cfg.data[0];
                    REG_LOG2_BLOCK_BYTES: log2_block_bytes_reg <= cfg.data;
                    REG_LOG2_SETS_USED:   log2_sets_used_reg   <= cfg.data[2:0];
                    REG_WAYS_USED:        ways_used_reg        <= cfg.data;
                    default:              ;
                endcase
            end

            if (mem_we)
            begin
                row_ok_vec_reg[set_reg] <= 1'b1;
                access_clock_reg        <= acc_new;
                if (!hit_any_reg)
                    fill_clock_reg <= fill_new;
            end

            // single-entry store: a match consumes it, anything else replaces it
            if (bypass_accept)
                bypass_valid_reg <= !bypass_hit;

            if (mem_we || bypass_accept)
                rsp_valid_reg <= 1'b1;
            else if (rsp.ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    // ---------------------------------------------------------------
    // Payload registers and tag memory
    // ---------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[set_reg] <= wr_row;
        if (cache_accept)
            rd_row_reg <= mem[set_in];
    end

    always_ff @(posedge clk)
    begin
        if (cache_accept)
        begin
            set_reg    <= set_in;
            tag_reg    <= tag_in;
            row_ok_reg <= row_ok_vec_reg[set_in];
        end
        if (state_reg == ST_CMP)
        begin
            hit_any_reg <= hit_any;
            hit_way_reg <= hit_way;
            inv_any_reg <= inv_any;
            inv_way_reg <= inv_way;
            for (int p = 0; p < NPAIR; p++)
                pair_reg[p] <= pair_cand[p];
        end
        if (bypass_accept && !bypass_hit)
            bypass_addr_reg <= req.access_addr;
        if (mem_we)
            rsp_hit_reg <= hit_any_reg;
        else if (bypass_accept)
            rsp_hit_reg <= bypass_hit;
    end

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_writeback_answers: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |=> rsp_valid_reg)
        else $error("write-back without a response");

    a_bypass_answers: assert property (@(posedge clk) disable iff (!rst_n)
        bypass_accept |=> (rsp_valid_reg && (state_reg == ST_IDLE)))
        else $error("bypass lookup did not answer next cycle");

    a_access_clock_monotone: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (access_clock_reg >= $past(access_clock_reg)))
        else $error("access clock went backward");

    a_fill_clock_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && hit_any_reg) |=> $stable(fill_clock_reg))
        else $error("fill clock moved on a hit");

endmodule

/* bench/set_assoc_cache_tag_lookup_core_tb.sv */
// Testbench for the set-associative tag lookup: predicts hit or miss per address and checks it.
module set_assoc_cache_tag_lookup_core_tb import satl_pkg::*;;

    localparam int LINES           = MAX_SETS * MAX_WAYS;
    localparam int RANDOM_ITEMS    = 1500;
    localparam int PRESSURE_AT     = 400;      // answer count that starts the long hold-off
    localparam int PRESSURE_CYCLES = 200;
    localparam int TAIL_CYCLES     = 20;
    localparam int LIMIT_CYCLES    = 400_000;

    // Indexes past the last register: the block must ignore writes to them
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef enum int { IDLE_NONE, IDLE_SOME, IDLE_FULL } idle_mode_e;

    // One pending item for the driver: a lookup address or a register write
    typedef struct packed {
        logic                  is_write;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        logic [ADDR_W-1:0]     addr;
        logic [3:0]            gap;
    } stim_t;

    // Expected answer, with its address for the report
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic              hit;
    } verdict_t;

    logic clk;
    logic rst_n;

    satl_cfg_if cfg_ch ();
    satl_req_if lookup_ch ();
    satl_rsp_if answer_ch ();

    set_assoc_cache_tag_lookup_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .req   (lookup_ch),
        .rsp   (answer_ch)
    );

    stim_t    pending_q[$];
    verdict_t hit_q[$];
    int       mismatches;

    // ------------------------------------------------------------------
    // Tag store mirror. Line (set, way) sits at set * MAX_WAYS + way.
    // ------------------------------------------------------------------
    logic               ln_valid  [LINES];
    logic [TAG_W-1:0]   ln_tag    [LINES];
    logic [CLOCK_W-1:0] ln_used   [LINES];
    logic [CLOCK_W-1:0] ln_filled [LINES];
    logic [CLOCK_W-1:0] use_tick;
    logic [CLOCK_W-1:0] fill_tick;
    logic               byp_valid;
    logic [ADDR_W-1:0]  byp_addr;

    // Register mirror, updated at each accepted write
    logic       m_enabled;
    logic       m_policy;
    logic [3:0] m_blk_shift;
    logic [2:0] m_set_bits;
    logic [3:0] m_ways;

    // Geometry the stimulus plans for, used to shape addresses
    logic       plan_en;
    logic [3:0] plan_blk;
    logic [2:0] plan_lss;
    logic [3:0] plan_ways;
    idle_mode_e tx_mode;

    // Work out hit or miss for one address and advance the mirror.
    function automatic logic predict_lookup(input logic [ADDR_W-1:0] addr);
        int                 ways;
        int                 sbits;
        int                 base;
        int                 slot;
        logic [TAG_W-1:0]   tag;
        logic [CLOCK_W-1:0] key;
        logic [CLOCK_W-1:0] best;
        // Bypass: one whole-address entry, a match hits and empties it
        if (!m_enabled)
        begin
            if (byp_valid && byp_addr == addr)
            begin
                byp_valid = 1'b0;
                return 1'b1;
            end
            byp_addr  = addr;
            byp_valid = 1'b1;
            return 1'b0;
        end
        // Clamp geometry: ways 0 acts as 1, oversize values fall to the built size
        ways  = (m_ways == 0) ? 1 : (m_ways > MAX_WAYS) ? MAX_WAYS : int'(m_ways);
        sbits = (m_set_bits > SET_BITS) ? SET_BITS : int'(m_set_bits);
        if (use_tick != CLOCK_MAX)
            use_tick = use_tick + 1'b1;
        base = int'((addr >> m_blk_shift) & ((32'd1 << sbits) - 32'd1)) * MAX_WAYS;
        tag  = addr >> (m_blk_shift + sbits);
        for (int w = 0; w < ways; w++)
        begin
            if (ln_valid[base + w] && ln_tag[base + w] == tag)
            begin
                ln_used[base + w] = use_tick;
                return 1'b1;
            end
        end
        // Miss: lowest empty way first, else oldest by policy, lowest way on ties
        slot = -1;
        for (int w = 0; w < ways && slot < 0; w++)
            if (!ln_valid[base + w])
                slot = base + w;
        if (slot < 0)
        begin
            slot = base;
            best = (m_policy == POLICY_FIFO) ? ln_filled[base] : ln_used[base];
            for (int w = 1; w < ways; w++)
            begin
                key = (m_policy == POLICY_FIFO) ? ln_filled[base + w] : ln_used[base + w];
                if (key < best)
                begin
                    best = key;
                    slot = base + w;
                end
            end
        end
        ln_valid[slot] = 1'b1;
        ln_tag[slot]   = tag;
        ln_used[slot]  = use_tick;
        if (fill_tick != CLOCK_MAX)
            fill_tick = fill_tick + 1'b1;
        ln_filled[slot] = fill_tick;
        return 1'b0;
    endfunction

    // Idle cycles before one item, by the current idling mode.
    function automatic int draw_gap(input idle_mode_e m);
        case (m)
            IDLE_NONE: return 0;
            IDLE_SOME: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 13) : 0;
            default:   return $urandom_range(0, 13);
        endcase
    endfunction

    task automatic push_lookup(input logic [ADDR_W-1:0] a);
        stim_t s;
        s          = '0;
        s.addr     = a;
        s.gap      = 4'(draw_gap(tx_mode));
        pending_q.push_back(s);
    endtask

    task automatic push_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        stim_t s;
        s          = '0;
        s.is_write = 1'b1;
        s.reg_idx  = idx;
        s.reg_val  = val;
        s.gap      = 4'(draw_gap(tx_mode));
        pending_q.push_back(s);
    endtask

    // Queue a write of every register and note the geometry for address shaping.
    task automatic write_geometry(input logic en, input logic pol, input logic [3:0] blk,
                                  input logic [2:0] lss, input logic [3:0] ways);
        push_write(REG_CACHE_ENABLED, 4'(en));
        push_write(REG_REPLACE_POLICY, 4'(pol));
        push_write(REG_LOG2_BLOCK_BYTES, blk);
        push_write(REG_LOG2_SETS_USED, 4'(lss));
        push_write(REG_WAYS_USED, ways);
        plan_en   = en;
        plan_blk  = blk;
        plan_lss  = lss;
        plan_ways = ways;
    endtask

    // ------------------------------------------------------------------
    // Clock, reset and the run limit
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    initial
    begin
        #(8 * LIMIT_CYCLES);
        $display("RESULT: ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Driver: offers pending items in order. A register write waits until
    // every accepted lookup has been answered, so the block is idle when
    // its geometry changes. The mirror advances at each accepted item.
    // ------------------------------------------------------------------
    int   in_flight;
    int   gap_left;
    logic gap_armed;

    always @(posedge clk or negedge rst_n)
    begin : lookup_driver
        logic     sent;
        logic     wrote;
        logic     req_hold;
        logic     cfg_hold;
        logic     outcome;
        stim_t    head;
        verdict_t v;
        if (!rst_n)
        begin
            lookup_ch.valid       <= 1'b0;
            lookup_ch.access_addr <= '0;
            cfg_ch.valid          <= 1'b0;
            cfg_ch.index          <= '0;
            cfg_ch.data           <= '0;
            in_flight = 0;
            gap_left  = 0;
            gap_armed = 1'b0;
            // Reset state of the block: empty store, reset register values
            for (int i = 0; i < LINES; i++)
            begin
                ln_valid[i]  = 1'b0;
                ln_tag[i]    = '0;
                ln_used[i]   = '0;
                ln_filled[i] = '0;
            end
            use_tick    = '0;
            fill_tick   = '0;
            byp_valid   = 1'b0;
            byp_addr    = '0;
            m_enabled   = 1'b1;
            m_policy    = POLICY_LRU;
            m_blk_shift = 4'd5;
            m_set_bits  = 3'd6;
            m_ways      = 4'd8;
        end
        else
        begin
            sent  = lookup_ch.valid && lookup_ch.ready;
            wrote = cfg_ch.valid && cfg_ch.ready;
            if (sent)
            begin
                outcome = predict_lookup(lookup_ch.access_addr);
                v.addr  = lookup_ch.access_addr;
                v.hit   = outcome;
                hit_q.push_back(v);
                in_flight++;
            end
            if (answer_ch.valid && answer_ch.ready)
                in_flight--;
            if (wrote)
            begin
                // Unknown indexes fall through and change nothing
                case (cfg_ch.index)
                    REG_CACHE_ENABLED:    m_enabled   = cfg_ch.data[0];
                    REG_REPLACE_POLICY:   m_policy    = cfg_ch.data[0];
                    REG_LOG2_BLOCK_BYTES: m_blk_shift = cfg_ch.data;
                    REG_LOG2_SETS_USED:   m_set_bits  = cfg_ch.data[2:0];
                    REG_WAYS_USED:        m_ways      = cfg_ch.data;
                    default: ;
                endcase
            end
            // Hold an item not yet taken; otherwise count down its gap and offer the next
            req_hold = lookup_ch.valid && !sent;
            cfg_hold = cfg_ch.valid && !wrote;
            if (!req_hold && !cfg_hold && pending_q.size() != 0)
            begin
                if (!gap_armed)
                begin
                    gap_left  = pending_q[0].gap;
                    gap_armed = 1'b1;
                end
                if (gap_left != 0)
                    gap_left--;
                else if (!pending_q[0].is_write || in_flight == 0)
                begin
                    head      = pending_q.pop_front();
                    gap_armed = 1'b0;
                    if (head.is_write)
                    begin
                        cfg_hold = 1'b1;
                        cfg_ch.index <= head.reg_idx;
                        cfg_ch.data  <= head.reg_val;
                    end
                    else
                    begin
                        req_hold = 1'b1;
                        lookup_ch.access_addr <= head.addr;
                    end
                end
            end
            lookup_ch.valid <= req_hold;
            cfg_ch.valid    <= cfg_hold;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: takes answers, compares each with the oldest expectation
    // and stalls at random. Once, after PRESSURE_AT answers, it holds
    // ready low for a long stretch so the block backs up into its input.
    // ------------------------------------------------------------------
    int         stall_left;
    int         answers;
    idle_mode_e rx_mode;

    always @(posedge clk or negedge rst_n)
    begin : answer_monitor
        verdict_t want;
        if (!rst_n)
        begin
            answer_ch.ready <= 1'b0;
            stall_left = 0;
            answers    = 0;
            rx_mode    = IDLE_NONE;
            mismatches = 0;
        end
        else
        begin
            if (answer_ch.valid && answer_ch.ready)
            begin
                answers++;
                if (hit_q.size() == 0)
                begin
                    $error("is_hit: no lookup outstanding, expected none, actual %0b",
                           answer_ch.is_hit);
                    mismatches++;
                end
                else
                begin
                    want = hit_q.pop_front();
                    if (answer_ch.is_hit !== want.hit)
                    begin
                        $error("is_hit for address %h: expected %0b, actual %0b",
                               want.addr, want.hit, answer_ch.is_hit);
                        mismatches++;
                    end
                end
                // Switch idling style now and then so stretches without stalls occur
                if (answers % 64 == 0)
                    rx_mode = idle_mode_e'($urandom_range(0, 2));
                stall_left = (answers == PRESSURE_AT) ? PRESSURE_CYCLES : draw_gap(rx_mode);
            end
            else if (stall_left != 0)
                stall_left--;
            answer_ch.ready <= (stall_left == 0);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus: a short directed part under reset geometry, then random
    // phases, each opening with writes of every register.
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int                lookups;
        int                phase_len;
        int                n_ways;
        int                n_sets;
        int                lss_eff;
        int                span;
        int                pick;
        logic [ADDR_W-1:0] tag_base;
        logic [ADDR_W-1:0] set_base;
        logic [ADDR_W-1:0] tag_pick;
        logic [ADDR_W-1:0] set_pick;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] last_addr;
        logic [ADDR_W-1:0] recent [4];

        tx_mode   = IDLE_NONE;
        plan_en   = 1'b1;
        plan_blk  = 4'd5;
        plan_lss  = 3'd6;
        plan_ways = 4'd8;

        // Extreme addresses; a second touch of the same block hits
        push_lookup(32'h0000_0000);
        push_lookup(32'h0000_001F);
        push_lookup(32'hFFFF_FFFF);
        push_lookup(32'hFFFF_FFE0);
        // Fill set 0 past its eight ways: the ninth tag evicts the least recently used
        for (int t = 1; t <= 8; t++)
            push_lookup(32'(t) << 11);
        push_lookup(32'h0000_0000);
        push_lookup(32'h0000_1000);
        // Same set under FIFO: the oldest fill goes, however recently it was used
        push_write(REG_REPLACE_POLICY, 4'(POLICY_FIFO));
        push_lookup(32'h0000_4800);
        push_lookup(32'h0000_1000);
        // Bypass entry: store, hit and clear, store again, replace, hit
        push_write(REG_CACHE_ENABLED, 4'd0);
        push_lookup(32'h1234_5678);
        push_lookup(32'h1234_5678);
        push_lookup(32'h1234_5678);
        push_lookup(32'hA5A5_A5A5);
        push_lookup(32'hA5A5_A5A5);

        lookups   = 0;
        last_addr = '0;
        for (int ph = 0; lookups < RANDOM_ITEMS; ph++)
        begin
            tx_mode = idle_mode_e'($urandom_range(0, 2));
            case (ph)
                0: write_geometry(1'b1, POLICY_LRU, 4'd5, 3'd6, 4'd8);
                1: write_geometry(1'b1, POLICY_LRU, 4'd0, 3'd0, 4'd1);
                2: write_geometry(1'b1, POLICY_FIFO, 4'd12, 3'd6, 4'd8);
                3: write_geometry(1'b1, POLICY_FIFO, 4'd15, 3'd7, 4'd15);
                4: write_geometry(1'b1, POLICY_LRU, 4'd3, 3'd2, 4'd0);
                5: write_geometry(1'b0, POLICY_FIFO, 4'd0, 3'd0, 4'd1);
                default: write_geometry($urandom_range(0, 9) != 0, 1'($urandom_range(0, 1)),
                                        4'($urandom_range(0, 15)), 3'($urandom_range(0, 7)),
                                        4'($urandom_range(0, 15)));
            endcase
            if ($urandom_range(0, 3) == 0)
                push_write(3'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)),
                           4'($urandom_range(0, 15)));

            // Working set: a few more tags than ways over two neighboring sets
            n_ways    = (plan_ways == 0) ? 1 : (plan_ways > MAX_WAYS) ? MAX_WAYS : int'(plan_ways);
            lss_eff   = (plan_lss > SET_BITS) ? SET_BITS : int'(plan_lss);
            n_sets    = 1 << lss_eff;
            span      = n_ways + int'($urandom_range(1, 3));
            tag_base  = $urandom();
            set_base  = 32'($urandom_range(0, n_sets - 1));
            for (int k = 0; k < 4; k++)
                recent[k] = $urandom();
            phase_len = $urandom_range(40, 160);

            for (int n = 0; n < phase_len; n++)
            begin
                pick = $urandom_range(0, 99);
                if (!plan_en)
                    addr = (pick < 50) ? last_addr
                         : (pick < 85) ? recent[$urandom_range(0, 3)] : $urandom();
                else if (pick < 10)
                    addr = $urandom();
                else
                begin
                    tag_pick = tag_base + 32'($urandom_range(0, span));
                    set_pick = (set_base + 32'($urandom_range(0, 1))) & 32'(n_sets - 1);
                    addr = (tag_pick << (plan_blk + lss_eff)) | (set_pick << plan_blk)
                         | ($urandom() & ((32'd1 << plan_blk) - 32'd1));
                end
                push_lookup(addr);
                last_addr = addr;
            end
            lookups += phase_len;
        end

        // Drain: everything offered, everything answered, then a short tail
        while (pending_q.size() != 0 || lookup_ch.valid || cfg_ch.valid || hit_q.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
        if (mismatches == 0 && hit_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
